/* sv/urxg_pkg.sv */
// Shared types and constants for the UART receiver with idle-gap frame detection.
package urxg_pkg;

  localparam int TpbW     = 16;
  localparam int GapW     = 8;
  localparam int GapCntW  = 24;
  localparam int SlotOutW = 5;
  localparam int CfgIdxW  = 2;

  localparam logic [TpbW-1:0] TpbMin   = 16'd4;
  localparam logic [TpbW-1:0] TpbReset = 16'd16;
  localparam logic [GapW-1:0] GapReset = 8'd19;

  localparam logic [CfgIdxW-1:0] CFG_TICKS_PER_BIT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_GAP_BITS      = 2'd1;

  // Effective bit timing, settled at configuration write time.
  typedef struct packed {
    logic [TpbW-1:0]    tpb;
    logic [GapCntW-1:0] gap_limit;
  } urxg_cfg_t;

  typedef struct packed {
    logic                byte_valid;
    logic [7:0]          rx_byte;
    logic [SlotOutW-1:0] buffer_slot;
    logic                framing_error;
    logic                frame_done;
  } urxg_result_t;

endpackage

/* sv/uart_rx_with_frame_gap_top.sv */
// Top level of the 8N1 UART receiver with idle-gap frame detection.
// Each input item is one sample of the receive line; each accepted item gives exactly one
// result item, registered and offered on the output channel the cycle after acceptance.
// One item is taken per clock cycle unless a result is held unread: the whole step is a single pass through the receive
// state machine, and an item is taken while the previous result is being taken downstream.
// A write to ticks_per_bit or gap_bits also updates the stored gap limit (their product)
// in the same cycle, so configuration takes effect on the very next item. A ticks_per_bit
// below 4 acts as 4 and a gap_bits of 0 acts as 1.
module uart_rx_with_frame_gap_top #(
  parameter int BUFFER_DEPTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           rx_level,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           byte_valid,
  output logic [7:0]                     rx_byte,
  output logic [urxg_pkg::SlotOutW-1:0]  buffer_slot,
  output logic                           framing_error,
  output logic                           frame_done,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [urxg_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [urxg_pkg::TpbW-1:0]      cfg_data
);
  import urxg_pkg::*;

  logic [GapW-1:0] gap_reg;
  urxg_cfg_t       cfg;
  urxg_result_t    res, res_reg;
  logic            step;

  logic [TpbW-1:0] new_tpb;
  logic [GapW-1:0] new_gap;

  assign cfg_ready = 1'b1;
  assign new_tpb   = (cfg_data < TpbMin) ? TpbMin : cfg_data;
  assign new_gap   = (cfg_data[GapW-1:0] == '0) ? GapW'(1) : cfg_data[GapW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_reg       <= GapReset;
      cfg.tpb       <= TpbReset;
      cfg.gap_limit <= GapCntW'(GapReset) * GapCntW'(TpbReset);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TICKS_PER_BIT: begin
          cfg.tpb       <= new_tpb;
          cfg.gap_limit <= GapCntW'(gap_reg == '0 ? GapW'(1) : gap_reg) * GapCntW'(new_tpb);
        end
        CFG_GAP_BITS: begin
          gap_reg       <= cfg_data[GapW-1:0];
          cfg.gap_limit <= GapCntW'(new_gap) * GapCntW'(cfg.tpb);
        end
        default: begin
        end
      endcase
    end
  end

  assign in_ready = !out_valid || out_ready;
  assign step     = in_valid && in_ready;

  urxg_core #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .step (step),
    .lvl  (rx_level),
    .res  (res)
  );

  // Hold the result until taken; load a new one on every accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_reg <= res;
    end
  end

  assign byte_valid    = res_reg.byte_valid;
  assign rx_byte       = res_reg.rx_byte;
  assign buffer_slot   = res_reg.buffer_slot;
  assign framing_error = res_reg.framing_error;
  assign frame_done    = res_reg.frame_done;

endmodule

/* sv/urxg_core.sv */
// Receive state machine: start detect, bit sampling, slot counting and gap timing.
module urxg_core #(
  parameter int BUFFER_DEPTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  urxg_pkg::urxg_cfg_t   cfg,
  input  logic                  step,
  input  logic                  lvl,
  output urxg_pkg::urxg_result_t res
);
  import urxg_pkg::*;

  localparam int SlotW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_START,
    PH_DATA,
    PH_STOP
  } phase_t;

  phase_t             phase, phase_next;
  logic [TpbW-1:0]    tick_count, tick_count_next;
  logic [3:0]         bit_index, bit_index_next;
  logic [7:0]         shift_byte, shift_byte_next;
  logic [SlotW-1:0]   write_slot, write_slot_next;
  logic [GapCntW-1:0] gap_count, gap_count_next;
  logic               gap_armed, gap_armed_next;
  logic               last_level;

  logic [TpbW-1:0]    tick_inc;
  logic [GapCntW-1:0] gap_inc;
  logic [3:0]         bit_inc;
  logic [8:0]         slot_ext;

  assign tick_inc = tick_count + 1'b1;
  assign gap_inc  = gap_count + 1'b1;
  assign bit_inc  = bit_index + 1'b1;
  assign slot_ext = 9'(write_slot);

  always_comb begin
    phase_next      = phase;
    tick_count_next = tick_count;
    bit_index_next  = bit_index;
    shift_byte_next = shift_byte;
    write_slot_next = write_slot;
    gap_count_next  = gap_count;
    gap_armed_next  = gap_armed;
    res             = '0;

    case (phase)
      PH_IDLE: begin
        if (last_level && !lvl) begin
          phase_next      = PH_START;
          tick_count_next = '0;
          gap_count_next  = '0;
        end else if (gap_armed) begin
          if (gap_inc >= cfg.gap_limit) begin
            res.frame_done = 1'b1;
            gap_armed_next = 1'b0;
            gap_count_next = '0;
          end else begin
            gap_count_next = gap_inc;
          end
        end
      end
      PH_START: begin
        gap_count_next  = '0;
        tick_count_next = tick_inc;
        if (tick_inc >= (cfg.tpb >> 1)) begin
          tick_count_next = '0;
          if (!lvl) begin
            phase_next      = PH_DATA;
            bit_index_next  = '0;
            shift_byte_next = '0;
            gap_armed_next  = 1'b1;
          end else begin
            // false start: drop back to idle
            phase_next = PH_IDLE;
          end
        end
      end
      PH_DATA: begin
        gap_count_next  = '0;
        tick_count_next = tick_inc;
        if (tick_inc >= cfg.tpb) begin
          tick_count_next = '0;
          if (lvl) begin
            shift_byte_next[bit_index[2:0]] = 1'b1;
          end
          bit_index_next = bit_inc;
          if (bit_inc >= 4'd8) begin
            phase_next = PH_STOP;
          end
        end
      end
      PH_STOP: begin
        gap_count_next  = '0;
        tick_count_next = tick_inc;
        if (tick_inc >= cfg.tpb) begin
          tick_count_next = '0;
          if (lvl) begin
            res.byte_valid  = 1'b1;
            res.rx_byte     = shift_byte;
            res.buffer_slot = slot_ext[SlotOutW-1:0];
            write_slot_next = (write_slot == SlotW'(BUFFER_DEPTH - 1)) ? '0
                                                                    : write_slot + 1'b1;
          end else begin
            res.framing_error = 1'b1;
          end
          shift_byte_next = '0;
          bit_index_next  = '0;
          phase_next      = PH_IDLE;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      tick_count <= '0;
      bit_index  <= '0;
      shift_byte <= '0;
      write_slot <= '0;
      gap_count  <= '0;
      gap_armed  <= 1'b0;
      last_level <= 1'b1;
    end else if (step) begin
      phase      <= phase_next;
      tick_count <= tick_count_next;
      bit_index  <= bit_index_next;
      shift_byte <= shift_byte_next;
      write_slot <= write_slot_next;
      gap_count  <= gap_count_next;
      gap_armed  <= gap_armed_next;
      last_level <= lvl;
    end
  end

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the UART receiver with idle-gap frame detection.
module testbench;
  import urxg_pkg::*;

  localparam int BufferDepth = 32;
  localparam int CycleLimit  = 400000;
  localparam logic [CfgIdxW-1:0] CFG_UNUSED = 2'd3;

  typedef enum logic [1:0] {RX_IDLE, RX_START, RX_DATA, RX_STOP} rx_state_e;
  typedef enum int {READY_ALWAYS, READY_COIN, READY_THIRD, READY_MOSTLY} ready_mode_e;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                rx_level = 1'b1;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                byte_valid;
  logic [7:0]          rx_byte;
  logic [SlotOutW-1:0] buffer_slot;
  logic                framing_error;
  logic                frame_done;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [TpbW-1:0]     cfg_data = '0;

  uart_rx_with_frame_gap_top #(.BUFFER_DEPTH(BufferDepth)) i_dut (
    .clk, .rst, .in_valid, .in_ready, .rx_level, .out_valid, .out_ready,
    .byte_valid, .rx_byte, .buffer_slot, .framing_error, .frame_done,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always #5 clk = ~clk;

  // Receiver state as the decoder sees it
  logic [TpbW-1:0]    cur_tpb = TpbReset;
  logic [GapW-1:0]    cur_gap = GapReset;
  rx_state_e          rx_state = RX_IDLE;
  logic [15:0]        bit_ticks = '0;
  logic [3:0]         bit_pos = '0;
  logic [7:0]         shift_reg = '0;
  int unsigned        write_slot = 0;
  logic [GapCntW-1:0] idle_ticks = '0;
  logic               gap_armed = 1'b0;
  logic               prev_level = 1'b1;

  bit           line_samples[$];
  urxg_result_t decoded_q[$];
  int           samples_queued = 0;
  int           results_seen = 0;
  int           fault_count = 0;
  int           cycle_count = 0;

  // Line timing used when building stimulus (effective values)
  int gen_tpb = 32'(TpbReset);
  int gen_gap = 32'(GapReset);

  function automatic urxg_result_t decode_sample(input logic lvl);
    urxg_result_t r;
    int unsigned  tpb;
    int unsigned  gap;
    r   = '0;
    tpb = 32'((cur_tpb < TpbMin) ? TpbMin : cur_tpb);
    gap = (cur_gap == 0) ? 1 : 32'(cur_gap);
    case (rx_state)
      RX_IDLE: begin
        if (prev_level && !lvl) begin
          rx_state   = RX_START;
          bit_ticks  = '0;
          idle_ticks = '0;
        end else if (gap_armed) begin
          idle_ticks = idle_ticks + 1'b1;
          if (idle_ticks >= gap * tpb) begin
            r.frame_done = 1'b1;
            gap_armed    = 1'b0;
            idle_ticks   = '0;
          end
        end
      end
      RX_START: begin
        idle_ticks = '0;
        bit_ticks  = bit_ticks + 1'b1;
        // recheck the start bit at mid-bit
        if (bit_ticks >= tpb / 2) begin
          bit_ticks = '0;
          if (!lvl) begin
            rx_state  = RX_DATA;
            bit_pos   = '0;
            shift_reg = '0;
            gap_armed = 1'b1;
          end else begin
            rx_state = RX_IDLE;
          end
        end
      end
      RX_DATA: begin
        idle_ticks = '0;
        bit_ticks  = bit_ticks + 1'b1;
        if (bit_ticks >= tpb) begin
          bit_ticks = '0;
          if (lvl) shift_reg[bit_pos[2:0]] = 1'b1;
          bit_pos = bit_pos + 1'b1;
          if (bit_pos >= 8) rx_state = RX_STOP;
        end
      end
      default: begin
        idle_ticks = '0;
        bit_ticks  = bit_ticks + 1'b1;
        if (bit_ticks >= tpb) begin
          bit_ticks = '0;
          if (lvl) begin
            r.byte_valid  = 1'b1;
            r.rx_byte     = shift_reg;
            r.buffer_slot = write_slot[SlotOutW-1:0];
            write_slot    = (write_slot + 1 >= BufferDepth) ? 0 : write_slot + 1;
          end else begin
            r.framing_error = 1'b1;
          end
          shift_reg = '0;
          bit_pos   = '0;
          rx_state  = RX_IDLE;
        end
      end
    endcase
    prev_level = lvl;
    return r;
  endfunction

  function automatic string fmt_result(input urxg_result_t r);
    return $sformatf("valid=%0b byte=%02h slot=%0d ferr=%0b done=%0b",
                     r.byte_valid, r.rx_byte, r.buffer_slot, r.framing_error, r.frame_done);
  endfunction

  task automatic report_fault(input string msg);
    fault_count++;
    if (fault_count <= 10) $display("%0t: %s", $time, msg);
  endtask

  // Sender: bursts of random length separated by random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin : drive
    logic free;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      free = !in_valid;
      if (in_valid && in_ready) begin
        decoded_q.push_back(decode_sample(rx_level));
        free = 1'b1;
      end
      if (free) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (line_samples.size() > 0) begin
          if (burst_left == 0)
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 12);
          in_valid <= 1'b1;
          rx_level <= line_samples.pop_front();
          burst_left--;
          if (burst_left == 0) gap_left = $urandom_range(0, 6);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern that changes mode every so often
  ready_mode_e ready_mode = READY_ALWAYS;
  int          ready_span = 0;

  always @(posedge clk) begin : watch
    urxg_result_t got;
    urxg_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{byte_valid, rx_byte, buffer_slot, framing_error, frame_done};
        results_seen++;
        if (decoded_q.size() == 0) begin
          report_fault({"unexpected result: ", fmt_result(got)});
        end else begin
          want = decoded_q.pop_front();
          if (got !== want)
            report_fault({"mismatch: want ", fmt_result(want), ", got ", fmt_result(got)});
        end
      end
      if (ready_span == 0) begin
        ready_mode = ready_mode_e'($urandom_range(0, 3));
        ready_span = $urandom_range(10, 200);
      end
      ready_span--;
      case (ready_mode)
        READY_ALWAYS: out_ready <= 1'b1;
        READY_COIN:   out_ready <= 1'($urandom_range(0, 1));
        READY_THIRD:  out_ready <= (ready_span % 3 == 0);
        default:      out_ready <= ($urandom_range(0, 4) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic put_level(input bit lvl, input int n);
    repeat (n) begin
      line_samples.push_back(lvl);
      samples_queued++;
    end
  endtask

  // One 8N1 character at the current bit time, LSB first
  task automatic put_char(input logic [7:0] b, input bit stop_level);
    put_level(1'b0, gen_tpb);
    for (int i = 0; i < 8; i++) put_level(b[i], gen_tpb);
    put_level(stop_level, gen_tpb);
  endtask

  task automatic random_traffic(input int n_samples);
    int goal;
    int pick;
    goal = samples_queued + n_samples;
    while (samples_queued < goal) begin
      pick = $urandom_range(0, 9);
      if (pick < 8) begin
        put_level(1'b1, $urandom_range(0, gen_tpb));
        put_char(8'($urandom_range(0, 255)), $urandom_range(0, 7) != 0);
      end else if (pick == 8 && gen_gap * gen_tpb <= 400) begin
        // idle long enough to close the frame
        put_level(1'b1, gen_gap * gen_tpb + $urandom_range(0, 3));
      end else if (pick == 8) begin
        // short low pulse: mostly a false start
        put_level(1'b0, $urandom_range(1, gen_tpb));
        put_level(1'b1, $urandom_range(1, gen_tpb));
      end else begin
        repeat ($urandom_range(1, 2 * gen_tpb)) put_level(1'($urandom_range(0, 1)), 1);
      end
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [TpbW-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_TICKS_PER_BIT) cur_tpb = value;
    else if (idx == CFG_GAP_BITS) cur_gap = value[GapW-1:0];
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_timing(input logic [TpbW-1:0] tpb, input logic [TpbW-1:0] gap);
    write_reg(CFG_TICKS_PER_BIT, tpb);
    write_reg(CFG_GAP_BITS, gap);
    gen_tpb = 32'((tpb < TpbMin) ? TpbMin : tpb);
    gen_gap = (gap[GapW-1:0] == 0) ? 1 : 32'(gap[GapW-1:0]);
  endtask

  // Every line sample yields one result; hold until all have come back
  task automatic wait_results();
    while (results_seen < samples_queued) @(posedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed traffic at the reset timing
    put_level(1'b1, 8);
    put_char(8'h00, 1'b1);
    put_char(8'hFF, 1'b1);
    put_level(1'b1, 3);
    put_char(8'hA5, 1'b0);
    put_level(1'b1, 2);
    put_char(8'h5A, 1'b1);
    put_level(1'b0, 5);
    put_level(1'b1, 20);
    put_level(1'b1, gen_gap * gen_tpb + 4);
    wait_results();

    // Register values below the minimum act as the minimum
    apply_timing(16'd0, 16'd0);
    random_traffic(150);
    wait_results();

    // Upper bits of the gap write are dropped
    apply_timing(TpbMin, 16'hAB02);
    random_traffic(150);
    wait_results();

    // Long gap: close the frame after 40 bit times
    apply_timing(16'd3, 16'd40);
    random_traffic(80);
    put_level(1'b1, gen_gap * gen_tpb + 8);
    wait_results();

    // Slowest bit time: the start bit is still pending when this phase ends
    apply_timing(16'hFFFF, 16'd1);
    put_level(1'b1, 4);
    put_level(1'b0, 100);
    wait_results();

    write_reg(CFG_UNUSED, 16'hFFFF);
    apply_timing(16'd6, 16'd3);
    random_traffic(120);
    wait_results();

    repeat (20) @(posedge clk);
    if (decoded_q.size() != 0)
      report_fault($sformatf("%0d results never arrived", decoded_q.size()));
    if (fault_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
